// ===== src/stack_machine_execute_defines.svh =====
// Assertion helpers for the checker file.
`ifndef STACK_MACHINE_EXECUTE_DEFINES_SVH
`define STACK_MACHINE_EXECUTE_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off during reset.
`define SME_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off during reset.
`define SME_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/sme_pkg.sv =====
`timescale 1ns / 1ps

package sme_pkg;

    localparam int DEF_STACK_DEPTH = 64;
    localparam int DEF_CALL_DEPTH  = 16;
    localparam int DEF_MEM_WORDS   = 4096;

    typedef logic [4:0] opcode_t;

    localparam opcode_t OP_ADD    = 5'd0;
    localparam opcode_t OP_SUB    = 5'd1;
    localparam opcode_t OP_MUL    = 5'd2;
    localparam opcode_t OP_DIV    = 5'd3;
    localparam opcode_t OP_SQRT   = 5'd4;
    localparam opcode_t OP_JMP    = 5'd5;
    localparam opcode_t OP_JE     = 5'd6;
    localparam opcode_t OP_JN     = 5'd7;
    localparam opcode_t OP_JL     = 5'd8;
    localparam opcode_t OP_JG     = 5'd9;
    localparam opcode_t OP_PUSH   = 5'd10;
    localparam opcode_t OP_POP    = 5'd11;
    localparam opcode_t OP_MOVRA  = 5'd12;
    localparam opcode_t OP_MOVRB  = 5'd13;
    localparam opcode_t OP_MOVRC  = 5'd14;
    localparam opcode_t OP_MOVRD  = 5'd15;
    localparam opcode_t OP_MOVM   = 5'd16;
    localparam opcode_t OP_PUSHRA = 5'd17;
    localparam opcode_t OP_PUSHRB = 5'd18;
    localparam opcode_t OP_PUSHRC = 5'd19;
    localparam opcode_t OP_PUSHRD = 5'd20;
    localparam opcode_t OP_PUSHM  = 5'd21;
    localparam opcode_t OP_IN     = 5'd22;
    localparam opcode_t OP_OUT    = 5'd23;
    localparam opcode_t OP_CALL   = 5'd24;
    localparam opcode_t OP_RET    = 5'd25;
    localparam opcode_t OP_END    = 5'd26;

    typedef logic [2:0] err_t;

    localparam err_t ERR_NONE    = 3'd0;
    localparam err_t ERR_UNDER   = 3'd1;
    localparam err_t ERR_OVER    = 3'd2;
    localparam err_t ERR_DIVZERO = 3'd3;
    localparam err_t ERR_NEGSQRT = 3'd4;
    localparam err_t ERR_CALLOVF = 3'd5;
    localparam err_t ERR_RETUND  = 3'd6;
    localparam err_t ERR_BADADDR = 3'd7;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic rd_a;
        logic capt_b;
        logic capt_a;
        logic alu_start;
        logic commit;
        logic clr_en;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clr_done;
        logic need_alu;
        logic alu_done;
        logic out_free;
    } sts_t;

endpackage

// ===== src/sme_ram.sv =====
`timescale 1ns / 1ps

module sme_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/sme_alu.sv =====
`timescale 1ns / 1ps

module sme_alu
    import sme_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  opcode_t            op,
    input  logic signed [31:0] a,
    input  logic signed [31:0] b,
    output logic               done,
    output logic [31:0]        result
);

    // Clip a magnitude to 2^31, apply the sign, saturate to 32 bits
    function automatic logic [31:0] sat_mag(input logic neg, input logic [47:0] mag);
        logic [31:0] m;
        m = (mag > 48'h0000_8000_0000) ? 32'h8000_0000 : mag[31:0];
        if (neg) begin
            return 32'(-m);
        end else if (m[31]) begin
            return 32'h7FFF_FFFF;
        end else begin
            return m;
        end
    endfunction

    logic               busy_reg;
    opcode_t            kind_reg;
    logic [5:0]         cnt_reg;
    logic               done_reg;
    logic [31:0]        res_reg;
    logic signed [63:0] prod_reg;
    logic [47:0]        num_reg;
    logic [31:0]        rem_reg;
    logic [31:0]        den_reg;
    logic               neg_reg;
    logic [47:0]        sq_n_reg;
    logic [47:0]        sq_r_reg;
    logic [47:0]        sq_bit_reg;

    logic [32:0] sum33;
    logic [32:0] dif33;
    logic [31:0] add_sat;
    logic [31:0] sub_sat;
    logic [31:0] ma;
    logic [31:0] mb;
    logic [47:0] num_init;
    logic [63:0] prod_mag;
    logic [63:0] prod_rnd;
    logic [32:0] div_sh;
    logic [33:0] div_diff;
    logic        qbit;
    logic [31:0] rem_next;
    logic [47:0] num_next;
    logic [47:0] sq_sum;
    logic        sq_ge;
    logic [47:0] sq_n_next;
    logic [47:0] sq_r_next;
    logic [47:0] sq_fin;

    // Combinational add/sub with saturation and divider setup
    always_comb begin
        sum33    = {a[31], a} + {b[31], b};
        dif33    = {a[31], a} - {b[31], b};
        add_sat  = (sum33[32] != sum33[31]) ?
                   (sum33[32] ? 32'h8000_0000 : 32'h7FFF_FFFF) : sum33[31:0];
        sub_sat  = (dif33[32] != dif33[31]) ?
                   (dif33[32] ? 32'h8000_0000 : 32'h7FFF_FFFF) : dif33[31:0];
        ma       = a[31] ? 32'(-a) : a;
        mb       = b[31] ? 32'(-b) : b;
        num_init = {ma, 16'h0000} + {17'd0, mb[31:1]};
    end

    // Product rounding, one division bit and one root step per cycle
    always_comb begin
        prod_mag  = prod_reg[63] ? 64'(-prod_reg) : prod_reg;
        prod_rnd  = prod_mag + 64'h8000;
        div_sh    = {rem_reg, num_reg[47]};
        div_diff  = {1'b0, div_sh} - {2'b00, den_reg};
        qbit      = !div_diff[33];
        rem_next  = qbit ? div_diff[31:0] : div_sh[31:0];
        num_next  = {num_reg[46:0], qbit};
        sq_sum    = sq_r_reg + sq_bit_reg;
        sq_ge     = (sq_n_reg >= sq_sum);
        sq_n_next = sq_ge ? (sq_n_reg - sq_sum) : sq_n_reg;
        sq_r_next = sq_ge ? ((sq_r_reg >> 1) + sq_bit_reg) : (sq_r_reg >> 1);
        sq_fin    = (sq_n_next > sq_r_next) ? (sq_r_next + 48'd1) : sq_r_next;
    end

    // Launch an operation, then iterate until its result is ready
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                kind_reg <= op;
                case (op)
                    OP_ADD: begin
                        res_reg  <= add_sat;
                        done_reg <= 1'b1;
                    end
                    OP_SUB: begin
                        res_reg  <= sub_sat;
                        done_reg <= 1'b1;
                    end
                    OP_MUL: begin
                        prod_reg <= a * b;
                        busy_reg <= 1'b1;
                    end
                    OP_DIV: begin
                        num_reg  <= num_init;
                        den_reg  <= mb;
                        rem_reg  <= '0;
                        neg_reg  <= a[31] ^ b[31];
                        cnt_reg  <= 6'd47;
                        busy_reg <= 1'b1;
                    end
                    OP_SQRT: begin
                        sq_n_reg   <= {b, 16'h0000};
                        sq_r_reg   <= '0;
                        sq_bit_reg <= 48'h4000_0000_0000;
                        cnt_reg    <= 6'd23;
                        busy_reg   <= 1'b1;
                    end
                    default: begin
                        res_reg  <= '0;
                        done_reg <= 1'b1;
                    end
                endcase
            end else if (busy_reg) begin
                case (kind_reg)
                    OP_MUL: begin
                        res_reg  <= sat_mag(prod_reg[63], prod_rnd[63:16]);
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                    OP_DIV: begin
                        num_reg <= num_next;
                        rem_reg <= rem_next;
                        cnt_reg <= cnt_reg - 6'd1;
                        if (cnt_reg == 6'd0) begin
                            res_reg  <= sat_mag(neg_reg, num_next);
                            busy_reg <= 1'b0;
                            done_reg <= 1'b1;
                        end
                    end
                    OP_SQRT: begin
                        sq_n_reg   <= sq_n_next;
                        sq_r_reg   <= sq_r_next;
                        sq_bit_reg <= sq_bit_reg >> 2;
                        cnt_reg    <= cnt_reg - 6'd1;
                        if (cnt_reg == 6'd0) begin
                            res_reg  <= sat_mag(1'b0, sq_fin);
                            busy_reg <= 1'b0;
                            done_reg <= 1'b1;
                        end
                    end
                    default: begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                endcase
            end
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

// ===== src/sme_ctrl.sv =====
`timescale 1ns / 1ps

module sme_ctrl
    import sme_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [7:0] {
        ST_CLEAR  = 8'b0000_0001,
        ST_IDLE   = 8'b0000_0010,
        ST_RD_B   = 8'b0000_0100,
        ST_RD_A   = 8'b0000_1000,
        ST_EVAL   = 8'b0001_0000,
        ST_START  = 8'b0010_0000,
        ST_WAIT   = 8'b0100_0000,
        ST_COMMIT = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Clear data memory after reset, then sequence one instruction: read operands, evaluate, compute if needed, commit
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr_en = 1'b1;
                if (sts.clr_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_RD_B;
                end
            end
            ST_RD_B: begin
                state_next = ST_RD_A;
            end
            ST_RD_A: begin
                cmd.rd_a   = 1'b1;
                cmd.capt_b = 1'b1;
                state_next = ST_EVAL;
            end
            ST_EVAL: begin
                cmd.rd_a   = 1'b1;
                cmd.capt_a = 1'b1;
                state_next = sts.need_alu ? ST_START : ST_COMMIT;
            end
            ST_START: begin
                cmd.alu_start = 1'b1;
                state_next    = ST_WAIT;
            end
            ST_WAIT: begin
                if (sts.alu_done) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                if (sts.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== src/sme_dpath.sv =====
`timescale 1ns / 1ps

module sme_dpath
    import sme_pkg::*;
#(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH,
    parameter int CALL_DEPTH  = DEF_CALL_DEPTH,
    parameter int MEM_WORDS   = DEF_MEM_WORDS
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  cmd_t               cmd,
    output sts_t               sts,
    input  logic [4:0]         s_opcode,
    input  logic signed [31:0] s_immediate,
    input  logic [15:0]        s_target,
    input  logic signed [31:0] s_in_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [15:0]        m_next_pc,
    output logic signed [31:0] m_out_value,
    output logic               m_out_valid,
    output logic               m_halted,
    output logic [2:0]         m_error_code
);

    localparam int SIDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int SP_W   = $clog2(STACK_DEPTH + 1);
    localparam int RIDX_W = (CALL_DEPTH > 1) ? $clog2(CALL_DEPTH) : 1;
    localparam int RSP_W  = $clog2(CALL_DEPTH + 1);
    localparam int MA_W   = $clog2(MEM_WORDS);

    // Instruction fields
    opcode_t            op_reg;
    logic signed [31:0] imm_reg;
    logic [15:0]        tgt_reg;
    logic signed [31:0] inv_reg;

    // Machine state
    logic [SP_W-1:0]    sp_reg;
    logic [RSP_W-1:0]   rsp_reg;
    logic [15:0]        pc_reg;
    logic               halt_reg;
    logic signed [31:0] gr_reg [4];
    logic [MA_W-1:0]    clr_idx_reg;

    // Fetched operands
    logic signed [31:0] b_reg;
    logic signed [31:0] a_reg;
    logic [15:0]        ret_reg;
    logic signed [31:0] memv_reg;

    // Result register
    logic               m_valid_reg;
    logic [15:0]        m_next_pc_reg;
    logic [31:0]        m_out_value_reg;
    logic               m_out_valid_reg;
    logic               m_halted_reg;
    err_t               m_error_code_reg;

    logic [31:0]        stk_rdata;
    logic [15:0]        ret_rdata;
    logic [31:0]        mem_rdata;
    logic [SIDX_W-1:0]  stk_raddr;
    logic               alu_done;
    logic [31:0]        alu_res;

    logic [SP_W-1:0]    sp_m1;
    logic [SP_W-1:0]    sp_m2;
    logic [15:0]        seq_pc;
    logic               two_words;
    logic               bad_addr;
    logic [4:0]         rel_push;
    logic [4:0]         rel_move;
    logic               taken;

    err_t               err;
    logic [15:0]        npc;
    logic               wr_stk;
    logic [SIDX_W-1:0]  wr_idx;
    logic [31:0]        wr_val;
    logic [31:0]        push_val;
    logic [SP_W-1:0]    sp_nx;
    logic [RSP_W-1:0]   rsp_nx;
    logic               push_ret;
    logic               mem_wr;
    logic               gr_wr;
    logic               out_ok;
    logic               halt_nx;
    logic               alu_needed;

    logic               mem_we;
    logic [MA_W-1:0]    mem_waddr;
    logic [31:0]        mem_wdata;

    // Address helpers
    always_comb begin
        sp_m1     = sp_reg - SP_W'(1);
        sp_m2     = sp_reg - SP_W'(2);
        stk_raddr = cmd.rd_a ? sp_m2[SIDX_W-1:0] : sp_m1[SIDX_W-1:0];
        two_words = op_reg inside {[OP_JMP:OP_PUSH], OP_MOVM, OP_PUSHM, OP_CALL};
        seq_pc    = pc_reg + (two_words ? 16'd2 : 16'd1);
        bad_addr  = ({1'b0, tgt_reg} >= 17'(MEM_WORDS));
        rel_push  = op_reg - OP_PUSHRA;
        rel_move  = op_reg - OP_MOVRA;
        case (op_reg)
            OP_JE:   taken = (a_reg == b_reg);
            OP_JN:   taken = (a_reg != b_reg);
            OP_JL:   taken = (a_reg < b_reg);
            default: taken = (a_reg > b_reg);
        endcase
        case (op_reg)
            OP_PUSH:  push_val = imm_reg;
            OP_PUSHM: push_val = memv_reg;
            OP_IN:    push_val = inv_reg;
            default:  push_val = gr_reg[rel_push[1:0]];
        endcase
    end

    // Decode: error checks, next pc and state effects of the held instruction
    always_comb begin
        err        = ERR_NONE;
        npc        = seq_pc;
        wr_stk     = 1'b0;
        wr_idx     = sp_reg[SIDX_W-1:0];
        wr_val     = push_val;
        sp_nx      = sp_reg;
        rsp_nx     = rsp_reg;
        push_ret   = 1'b0;
        mem_wr     = 1'b0;
        gr_wr      = 1'b0;
        out_ok     = 1'b0;
        halt_nx    = halt_reg;
        alu_needed = 1'b0;
        case (op_reg)
            OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                if (sp_reg < SP_W'(2)) begin
                    err = ERR_UNDER;
                end else if (op_reg == OP_DIV && b_reg == 32'sd0) begin
                    err = ERR_DIVZERO;
                end else begin
                    alu_needed = 1'b1;
                    wr_stk     = 1'b1;
                    wr_idx     = sp_m2[SIDX_W-1:0];
                    wr_val     = alu_res;
                    sp_nx      = sp_m1;
                end
            end
            OP_SQRT: begin
                if (sp_reg == '0) begin
                    err = ERR_UNDER;
                end else if (b_reg[31]) begin
                    err = ERR_NEGSQRT;
                end else begin
                    alu_needed = 1'b1;
                    wr_stk     = 1'b1;
                    wr_idx     = sp_m1[SIDX_W-1:0];
                    wr_val     = alu_res;
                end
            end
            OP_JMP: begin
                npc = tgt_reg;
            end
            OP_JE, OP_JN, OP_JL, OP_JG: begin
                if (sp_reg < SP_W'(2)) begin
                    err = ERR_UNDER;
                end else begin
                    sp_nx = sp_m2;
                    if (taken) begin
                        npc = tgt_reg;
                    end
                end
            end
            OP_PUSH, OP_PUSHRA, OP_PUSHRB, OP_PUSHRC, OP_PUSHRD, OP_PUSHM, OP_IN: begin
                if (sp_reg >= SP_W'(STACK_DEPTH)) begin
                    err = ERR_OVER;
                end else if (op_reg == OP_PUSHM && bad_addr) begin
                    err = ERR_BADADDR;
                end else begin
                    wr_stk = 1'b1;
                    sp_nx  = sp_reg + SP_W'(1);
                end
            end
            OP_POP, OP_MOVRA, OP_MOVRB, OP_MOVRC, OP_MOVRD, OP_MOVM: begin
                if (sp_reg == '0) begin
                    err = ERR_UNDER;
                end else if (op_reg == OP_MOVM && bad_addr) begin
                    err = ERR_BADADDR;
                end else begin
                    sp_nx = sp_m1;
                    if (op_reg == OP_MOVM) begin
                        mem_wr = 1'b1;
                    end else if (op_reg != OP_POP) begin
                        gr_wr = 1'b1;
                    end
                end
            end
            OP_OUT: begin
                if (sp_reg == '0) begin
                    err = ERR_UNDER;
                end else begin
                    out_ok = 1'b1;
                end
            end
            OP_CALL: begin
                if (rsp_reg >= RSP_W'(CALL_DEPTH)) begin
                    err = ERR_CALLOVF;
                end else begin
                    push_ret = 1'b1;
                    rsp_nx   = rsp_reg + RSP_W'(1);
                    npc      = tgt_reg;
                end
            end
            OP_RET: begin
                if (rsp_reg == '0) begin
                    err = ERR_RETUND;
                end else begin
                    rsp_nx = rsp_reg - RSP_W'(1);
                    npc    = ret_reg;
                end
            end
            OP_END: begin
                halt_nx = 1'b1;
                npc     = pc_reg;
            end
            default: begin
            end
        endcase
        // Drop every effect on an error or once halted
        if (halt_reg || err != ERR_NONE) begin
            if (halt_reg) begin
                err = ERR_NONE;
            end
            halt_nx    = 1'b1;
            npc        = pc_reg;
            wr_stk     = 1'b0;
            sp_nx      = sp_reg;
            rsp_nx     = rsp_reg;
            push_ret   = 1'b0;
            mem_wr     = 1'b0;
            gr_wr      = 1'b0;
            out_ok     = 1'b0;
            alu_needed = 1'b0;
        end
    end

    // Data memory port is shared by the clearing pass and the commit
    always_comb begin
        mem_we    = cmd.clr_en || (cmd.commit && mem_wr);
        mem_waddr = cmd.clr_en ? clr_idx_reg : tgt_reg[MA_W-1:0];
        mem_wdata = cmd.clr_en ? 32'd0 : b_reg;
    end

    sme_ram #(
        .WIDTH (32),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .aclk  (aclk),
        .we    (cmd.commit && wr_stk),
        .waddr (wr_idx),
        .wdata (wr_val),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    sme_ram #(
        .WIDTH (16),
        .DEPTH (CALL_DEPTH)
    ) u_rstack (
        .aclk  (aclk),
        .we    (cmd.commit && push_ret),
        .waddr (rsp_reg[RIDX_W-1:0]),
        .wdata (seq_pc),
        .raddr (rsp_nx[RIDX_W-1:0]),
        .rdata (ret_rdata)
    );

    sme_ram #(
        .WIDTH (32),
        .DEPTH (MEM_WORDS)
    ) u_dmem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (tgt_reg[MA_W-1:0]),
        .rdata (mem_rdata)
    );

    sme_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.alu_start),
        .op      (op_reg),
        .a       (a_reg),
        .b       (b_reg),
        .done    (alu_done),
        .result  (alu_res)
    );

    // Hold the instruction and the fetched operands
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg  <= s_opcode;
            imm_reg <= s_immediate;
            tgt_reg <= s_target;
            inv_reg <= s_in_value;
        end
        if (cmd.capt_b) begin
            b_reg <= stk_rdata;
        end
        if (cmd.capt_a) begin
            a_reg    <= stk_rdata;
            ret_reg  <= ret_rdata;
            memv_reg <= mem_rdata;
        end
    end

    // Advance the clear index while clearing, and machine state on commit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sp_reg      <= '0;
            rsp_reg     <= '0;
            pc_reg      <= '0;
            halt_reg    <= 1'b0;
            clr_idx_reg <= '0;
            for (int i = 0; i < 4; i++) begin
                gr_reg[i] <= '0;
            end
        end else begin
            if (cmd.clr_en) begin
                clr_idx_reg <= clr_idx_reg + MA_W'(1);
            end
            if (cmd.commit) begin
                sp_reg   <= sp_nx;
                rsp_reg  <= rsp_nx;
                pc_reg   <= npc;
                halt_reg <= halt_nx;
                if (gr_wr) begin
                    gr_reg[rel_move[1:0]] <= b_reg;
                end
            end
        end
    end

    // Result register: load on commit, drop on transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_next_pc_reg    <= npc;
            m_out_value_reg  <= out_ok ? b_reg : 32'd0;
            m_out_valid_reg  <= out_ok;
            m_halted_reg     <= halt_nx;
            m_error_code_reg <= err;
        end
    end

    always_comb begin
        sts.clr_done = (clr_idx_reg == MA_W'(MEM_WORDS - 1));
        sts.need_alu = alu_needed;
        sts.alu_done = alu_done;
        sts.out_free = !m_valid_reg || m_ready;
    end

    assign m_valid      = m_valid_reg;
    assign m_next_pc    = m_next_pc_reg;
    assign m_out_value  = m_out_value_reg;
    assign m_out_valid  = m_out_valid_reg;
    assign m_halted     = m_halted_reg;
    assign m_error_code = m_error_code_reg;

endmodule

// ===== src/stack_machine_execute.sv =====
`timescale 1ns / 1ps
// Each input transfer yields one result; add, sub, mul, div and sqrt also use the ALU
// when they pass their checks (one quotient bit or root step per cycle).
// No new instruction is taken until the last one commits; the controller walks one
// instruction at a time through two registered operand-stack reads and the ALU.
// Reset: synchronous active-low aresetn; then every data memory word is cleared
// before the first input transfer.
module stack_machine_execute
    import sme_pkg::*;
#(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH,
    parameter int CALL_DEPTH  = DEF_CALL_DEPTH,
    parameter int MEM_WORDS   = DEF_MEM_WORDS
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [4:0]         s_opcode,
    input  logic signed [31:0] s_immediate,
    input  logic [15:0]        s_target,
    input  logic signed [31:0] s_in_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [15:0]        m_next_pc,
    output logic signed [31:0] m_out_value,
    output logic               m_out_valid,
    output logic               m_halted,
    output logic [2:0]         m_error_code
);

    cmd_t cmd;
    sts_t sts;

    sme_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    sme_dpath #(
        .STACK_DEPTH (STACK_DEPTH),
        .CALL_DEPTH  (CALL_DEPTH),
        .MEM_WORDS   (MEM_WORDS)
    ) u_dpath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .s_opcode     (s_opcode),
        .s_immediate  (s_immediate),
        .s_target     (s_target),
        .s_in_value   (s_in_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_next_pc    (m_next_pc),
        .m_out_value  (m_out_value),
        .m_out_valid  (m_out_valid),
        .m_halted     (m_halted),
        .m_error_code (m_error_code)
    );

endmodule

// ===== src/sme_checker.sv =====
`timescale 1ns / 1ps
`include "stack_machine_execute_defines.svh"

module sme_checker
    import sme_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [15:0] m_next_pc,
    input logic [31:0] m_out_value,
    input logic        m_out_valid,
    input logic        m_halted,
    input logic [2:0]  m_error_code
);

    logic halted_seen_reg;
    logic halted_seen_next;

    // Remember that a halted result has been transferred
    always_comb begin
        halted_seen_next = halted_seen_reg || (m_valid && m_ready && m_halted);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            halted_seen_reg <= 1'b0;
        end else begin
            halted_seen_reg <= halted_seen_next;
        end
    end

    `SME_ASSERT_NOW(a_err_halts, m_valid && m_error_code != ERR_NONE, m_halted, "error without halt")
    `SME_ASSERT_NOW(a_out_clean, m_valid && m_out_valid, !m_halted && m_error_code == ERR_NONE, "out with halt or error")
    `SME_ASSERT_NOW(a_out_zero, m_valid && !m_out_valid, m_out_value == 32'd0, "out_value set without out")
    `SME_ASSERT_NOW(a_halt_sticky, m_valid && halted_seen_reg, m_halted && m_error_code == ERR_NONE, "halt lost")
    `SME_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_next_pc), "stalled result changed")

endmodule

bind stack_machine_execute sme_checker u_sme_checker (.*);
